// ===== hw/rtl/alcp_pkg.sv =====
// alcp_pkg: shared types and constants for the arc length to curve parameter block
// no dependencies
`default_nettype none

package alcp_pkg;

    localparam int PARAM_W  = 17;
    localparam int LEN_W    = 32;
    localparam int IDX_W    = 11;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;

    localparam logic [PARAM_W-1:0] PARAM_ONE  = 17'd65536;
    localparam logic [PARAM_W-1:0] PARAM_ZERO = 17'd0;

    localparam logic [CMD_W-1:0] CMD_WR_SAMPLE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_SEGMENT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 2'd2;

    localparam logic [KIND_W-1:0] KIND_INTERP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ZERO   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOTAL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IDX_W-1:0]   entry_index;
        logic [PARAM_W-1:0] sample_param;
        logic [LEN_W-1:0]   arc_length;
    } in_word_t;

    typedef struct packed {
        logic [PARAM_W-1:0] curve_param;
        logic [KIND_W-1:0]  clamp_kind;
    } out_word_t;

    // divider handshake
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [PARAM_W-1:0] base;
    } div_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/alcp_if.sv =====
// alcp_in_if / alcp_out_if: valid/ready channels for the lookup block
// depends on alcp_pkg
`default_nettype none

interface alcp_in_if;
    logic             valid;
    logic             ready;
    alcp_pkg::in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface alcp_out_if;
    logic              valid;
    logic              ready;
    alcp_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/arc_length_to_curve_parameter.sv =====
// arc_length_to_curve_parameter: table lookup of curve parameter from arc length
// depends on alcp_pkg, alcp_if, alcp_div
//
//  channel   dir  payload                                            handshake
//  in_ch     in   command, entry_index, sample_param, arc_length      valid/ready
//  out_ch    out  curve_param, clamp_kind                             valid/ready
//  cfg       in   total_length                                        cfg_we/cfg_wdata
//
// a write is stored as it is taken; a clamped query has its result out in the
// cycle after it is taken; an interpolated query walks the segment memory (up to
// MAX_SEGMENTS), binary-searches the sample memory (six or seven probes), reads the
// two samples and runs a serial divide; a flat or falling step skips the divide
// one word in flight; a new word is taken in the cycle the held result leaves
// tables are not cleared at reset and must be written before they are read
`default_nettype none

module arc_length_to_curve_parameter
#(
    parameter int MAX_SEGMENTS        = 16,
    parameter int SAMPLES_PER_SEGMENT = 100
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    alcp_in_if.sink          in_ch,
    alcp_out_if.source       out_ch,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    localparam int DEPTH = MAX_SEGMENTS * SAMPLES_PER_SEGMENT + 1;
    localparam int SA_W  = $clog2(DEPTH);
    localparam int SG_W  = $clog2(MAX_SEGMENTS + 1);
    localparam int CNT_W = $clog2(SAMPLES_PER_SEGMENT + 2);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SEGRD = 4'd1;
    localparam logic [3:0] ST_SEGCK = 4'd2;
    localparam logic [3:0] ST_BSRD  = 4'd3;
    localparam logic [3:0] ST_BSCK  = 4'd4;
    localparam logic [3:0] ST_RD0   = 4'd5;
    localparam logic [3:0] ST_RD1   = 4'd6;
    localparam logic [3:0] ST_PREP  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // memories
    logic [alcp_pkg::PARAM_W-1:0] par_mem [DEPTH];
    logic [31:0]                  len_mem [DEPTH];
    logic [31:0]                  seg_mem [MAX_SEGMENTS+1];

    logic [31:0] total_reg;
    logic [3:0]  state_reg;
    logic [31:0] s_reg;
    logic [SG_W-1:0] seg_reg;
    logic [SA_W-1:0] first_reg, start_reg, end_reg, it_reg, sel_reg;
    logic [CNT_W-1:0] count_reg, step_reg;
    logic [SA_W-1:0] rd_addr;
    logic            rd_en;
    logic [alcp_pkg::PARAM_W-1:0] par_q, u0_reg, u1_reg;
    logic [31:0] len_q, seg_q, s0_reg, s1_reg;
    logic [SG_W-1:0] seg_addr;
    logic            out_valid_reg;
    logic            res_load;
    alcp_pkg::out_word_t out_reg;

    alcp_pkg::div_ctl_t dctl;
    logic [48:0] dnum_reg;
    logic [32:0] dden_reg;
    logic        ddone;
    logic [alcp_pkg::PARAM_W-1:0] dres;

    logic [17:0] du_abs;
    logic [31:0] ds_off;
    logic        du_neg;
    logic        s_below;
    logic [SA_W-1:0] sel_fix;

    alcp_pkg::in_word_t iw;
    logic acc;

    assign iw = in_ch.data;

    assign in_ch.ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ch.ready);
    assign acc = in_ch.valid && in_ch.ready;

    // a result word is loaded into the output register this cycle
    assign res_load = (acc && iw.command == alcp_pkg::CMD_QUERY
                       && (iw.arc_length == 32'd0 || iw.arc_length >= total_reg))
                   || (state_reg == ST_PREP && len_q <= s0_reg)
                   || (state_reg == ST_OUT && ddone);

    // table writes and registered table reads
    always_ff @(posedge clk)
    begin
        if (acc && iw.command == alcp_pkg::CMD_WR_SAMPLE
            && {21'd0, iw.entry_index} < DEPTH)
        begin
            par_mem[iw.entry_index[SA_W-1:0]] <= (iw.sample_param > alcp_pkg::PARAM_ONE)
                ? alcp_pkg::PARAM_ONE : iw.sample_param;
            len_mem[iw.entry_index[SA_W-1:0]] <= iw.arc_length;
        end
        if (acc && iw.command == alcp_pkg::CMD_WR_SEGMENT
            && {21'd0, iw.entry_index} <= MAX_SEGMENTS)
            seg_mem[iw.entry_index[SG_W-1:0]] <= iw.arc_length;
        if (rd_en)
        begin
            par_q <= par_mem[rd_addr];
            len_q <= len_mem[rd_addr];
        end
        seg_q <= seg_mem[seg_addr];
    end

    assign seg_addr = seg_reg;

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = it_reg;
        case (state_reg)
            ST_BSRD: rd_en = 1'b1;
            ST_RD0:
            begin
                rd_en   = 1'b1;
                rd_addr = sel_fix - 1'b1;
            end
            ST_RD1:
            begin
                rd_en   = 1'b1;
                rd_addr = sel_reg;
            end
            default: rd_en = 1'b0;
        endcase
    end

    // clamp the search result into (start, end)
    always_comb
    begin
        sel_fix = first_reg;
        if (first_reg >= end_reg)
            sel_fix = end_reg - 1'b1;
        if (sel_fix <= start_reg)
            sel_fix = start_reg + 1'b1;
    end

    // offset sign is the sign of du times the sign of (s - s0)
    assign du_neg  = u1_reg < u0_reg;
    assign du_abs  = du_neg ? {1'b0, u0_reg - u1_reg} : {1'b0, u1_reg - u0_reg};
    assign s_below = s_reg < s0_reg;
    assign ds_off  = s_below ? (s0_reg - s_reg) : (s_reg - s0_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dctl          <= '0;
        end
        else
        begin
            dctl.start <= (state_reg == ST_DIV);
            if (cfg_we)
                total_reg <= cfg_wdata;
            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc && iw.command == alcp_pkg::CMD_QUERY)
                    begin
                        if (iw.arc_length == 32'd0)
                        begin
                            out_reg.curve_param <= alcp_pkg::PARAM_ZERO;
                            out_reg.clamp_kind  <= alcp_pkg::KIND_ZERO;
                        end
                        else if (iw.arc_length >= total_reg)
                        begin
                            out_reg.curve_param <= alcp_pkg::PARAM_ONE;
                            out_reg.clamp_kind  <= alcp_pkg::KIND_TOTAL;
                        end
                        else
                        begin
                            seg_reg   <= SG_W'(1);
                            state_reg <= (MAX_SEGMENTS > 1) ? ST_SEGRD : ST_SEGCK;
                        end
                    end
                end
                ST_SEGRD: state_reg <= ST_SEGCK;
                ST_SEGCK:
                begin
                    if ({{(32-SG_W){1'b0}}, seg_reg} < MAX_SEGMENTS && s_reg > seg_q)
                    begin
                        seg_reg   <= seg_reg + 1'b1;
                        state_reg <= ST_SEGRD;
                    end
                    else
                    begin
                        start_reg <= SA_W'((32'(seg_reg) - 1) * SAMPLES_PER_SEGMENT);
                        first_reg <= SA_W'((32'(seg_reg) - 1) * SAMPLES_PER_SEGMENT);
                        end_reg   <= SA_W'(32'(seg_reg) * SAMPLES_PER_SEGMENT + 1);
                        count_reg <= CNT_W'(SAMPLES_PER_SEGMENT + 1);
                        it_reg    <= SA_W'((32'(seg_reg) - 1) * SAMPLES_PER_SEGMENT
                                     + (SAMPLES_PER_SEGMENT + 1) / 2);
                        step_reg  <= CNT_W'((SAMPLES_PER_SEGMENT + 1) / 2);
                        state_reg <= ST_BSRD;
                    end
                end
                ST_BSRD: state_reg <= ST_BSCK;
                ST_BSCK:
                begin
                    if (!(s_reg < len_q))
                    begin
                        first_reg <= it_reg + 1'b1;
                        count_reg <= count_reg - step_reg - 1'b1;
                        step_reg  <= (count_reg - step_reg - 1'b1) >> 1;
                        it_reg    <= it_reg + 1'b1 + SA_W'((count_reg - step_reg - 1'b1) >> 1);
                        state_reg <= (count_reg - step_reg - 1'b1 == '0) ? ST_RD0 : ST_BSRD;
                    end
                    else
                    begin
                        count_reg <= step_reg;
                        step_reg  <= step_reg >> 1;
                        it_reg    <= first_reg + SA_W'(step_reg >> 1);
                        state_reg <= (step_reg == '0) ? ST_RD0 : ST_BSRD;
                    end
                end
                ST_RD0:
                begin
                    sel_reg   <= sel_fix;
                    state_reg <= ST_RD1;
                end
                ST_RD1:
                begin
                    u0_reg    <= par_q;
                    s0_reg    <= len_q;
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    u1_reg <= par_q;
                    s1_reg <= len_q;
                    if (len_q <= s0_reg)
                    begin
                        out_reg.curve_param <= u0_reg;
                        out_reg.clamp_kind  <= alcp_pkg::KIND_INTERP;
                        state_reg           <= ST_IDLE;
                    end
                    else
                        state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // operands are held in registers; the product is registered into dnum_reg here
                    dnum_reg   <= 49'(du_abs) * 49'(ds_off);
                    dden_reg   <= {1'b0, s1_reg - s0_reg};
                    dctl.neg   <= du_neg ^ s_below;
                    dctl.base  <= u0_reg;
                    state_reg  <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (ddone)
                    begin
                        out_reg.curve_param <= dres;
                        out_reg.clamp_kind  <= alcp_pkg::KIND_INTERP;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            s_reg <= iw.arc_length;
    end

    alcp_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (dctl),
        .num    (dnum_reg),
        .den    (dden_reg),
        .done   (ddone),
        .result (dres)
    );

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/alcp_div.sv =====
// alcp_div: bit-serial unsigned divide with rounding and final add to or subtract from base parameter
// depends on alcp_pkg
`default_nettype none

module alcp_div
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire alcp_pkg::div_ctl_t      ctl,
    input  wire logic [48:0]             num,
    input  wire logic [32:0]             den,
    output logic                         done,
    output logic [alcp_pkg::PARAM_W-1:0] result
);

    logic [49:0] rem_reg, rem_next;
    logic [49:0] quo_reg, quo_next;
    logic [32:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        neg_reg;
    logic [alcp_pkg::PARAM_W-1:0] base_reg;
    logic [50:0] trial;
    logic [18:0] res_s;

    assign trial = {rem_reg, quo_reg[49]} - {18'd0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (busy_reg)
        begin
            if (!trial[50])
            begin
                rem_next = trial[49:0];
                quo_next = {quo_reg[48:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[48:0], quo_reg[49]};
                quo_next = {quo_reg[48:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && (cnt_reg == 6'd1);
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd50;
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            // dividend carries half the divisor for round-half-up
            rem_reg  <= '0;
            quo_reg  <= {1'b0, num} + {18'd0, den[32:1]};
            den_reg  <= den;
            neg_reg  <= ctl.neg;
            base_reg <= ctl.base;
        end
        else
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // a quotient of 2^17 or more saturates either way; below that the sum fits 18 bits
    always_comb
    begin
        res_s = '0;
        if (|quo_reg[49:17])
            result = neg_reg ? alcp_pkg::PARAM_ZERO : alcp_pkg::PARAM_ONE;
        else
        begin
            if (neg_reg)
                res_s = {2'b0, base_reg} - {2'b0, quo_reg[16:0]};
            else
                res_s = {2'b0, base_reg} + {2'b0, quo_reg[16:0]};
            if (res_s[18])
                result = alcp_pkg::PARAM_ZERO;
            else if (res_s[17:0] > {1'b0, alcp_pkg::PARAM_ONE})
                result = alcp_pkg::PARAM_ONE;
            else
                result = res_s[16:0];
        end
    end

endmodule

`default_nettype wire
